// ===== rtl/refcounted_block_lock_table_macros.svh =====
// Assertion macros used by the lock table checker.
`ifndef REFCOUNTED_BLOCK_LOCK_TABLE_MACROS_SVH
`define REFCOUNTED_BLOCK_LOCK_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RBLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rblt_pkg.sv =====
// Shared constants, types and codes of the reference-counted lock table.
package rblt_pkg;

    localparam int BUCKET_BITS = 10;
    localparam int WAYS        = 4;
    localparam int COUNT_BITS  = 16;

    localparam int KEY_W       = 64;
    localparam int HANDLE_W    = 12;
    localparam int OUT_COUNT_W = 16;
    localparam int STATUS_W    = 3;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 32;

    localparam int ROWS      = 1 << BUCKET_BITS;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRY_W   = BUCKET_BITS + WAY_W;
    localparam int N_ENTRIES = ROWS * WAYS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [KEY_W-1:0]      GOLDEN64  = 64'h61C8864680B583EB;

    // Handle / WAYS as a multiply by a rounded-up reciprocal; exact for all handles.
    localparam int DIV_SHIFT = HANDLE_W + 5;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int DPROD_W   = HANDLE_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((1 << DIV_SHIFT) + WAYS - 1) / WAYS);

    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HELD     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FREED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SAT      = 3'd6;

    typedef struct packed {
        logic                   op;
        logic [KEY_W-1:0]       key;
        logic [HANDLE_W-1:0]    handle;
        logic [BUCKET_BITS-1:0] row;
        logic [WAY_W-1:0]       way;
        logic                   in_range;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_WAIT,
        BK_EXEC
    } back_state_t;

endpackage

// ===== rtl/rblt_front.sv =====
// Front end: accepts requests, hashes keys and splits handles into row and way.
module rblt_front import rblt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // block_number[63:0], entry_handle[75:64]
    input  logic                 s_tuser,    // op[0]
    input  logic                 clear_busy,
    input  queue_stat_t          q_stat,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    logic                   busy_reg, busy_next;
    logic                   accept;
    logic [KEY_W-1:0]       key_in;
    logic [HANDLE_W-1:0]    handle_in;

    logic                   op_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [HANDLE_W-1:0]    handle_reg;
    logic [63:0]            lo_reg;
    logic [31:0]            c1_reg;
    logic [31:0]            c2_reg;
    logic [DPROD_W-1:0]     dprod_reg;

    logic [31:0]            hash_top;
    logic [BUCKET_BITS-1:0] bucket;
    logic [HANDLE_W-1:0]    quot;
    logic [HANDLE_W-1:0]    quot_x_ways;
    logic [HANDLE_W-1:0]    rem;

    assign key_in    = s_tdata[KEY_W-1:0];
    assign handle_in = s_tdata[KEY_W +: HANDLE_W];

    assign s_tready = ~clear_busy & (~busy_reg | ~q_stat.full);
    assign accept   = s_tvalid & s_tready;
    assign q_push   = busy_reg & ~q_stat.full;

    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (q_push) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    // The 64-bit hash product modulo 2^64 is split into three 32x32 partial products.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_tuser;
            key_reg    <= key_in;
            handle_reg <= handle_in;
            lo_reg     <= 64'(key_in[31:0]) * 64'(GOLDEN64[31:0]);
            c1_reg     <= key_in[63:32] * GOLDEN64[31:0];
            c2_reg     <= key_in[31:0] * GOLDEN64[63:32];
            dprod_reg  <= DPROD_W'(handle_in) * DPROD_W'(DIV_RECIP);
        end
    end

    assign hash_top    = lo_reg[63:32] + c1_reg + c2_reg;
    assign bucket      = hash_top[31 -: BUCKET_BITS];
    assign quot        = dprod_reg[DIV_SHIFT +: HANDLE_W];
    assign quot_x_ways = HANDLE_W'(quot * HANDLE_W'(WAYS));
    assign rem         = handle_reg - quot_x_ways;

    always_comb begin
        q_cmd.op       = op_reg;
        q_cmd.key      = key_reg;
        q_cmd.handle   = handle_reg;
        q_cmd.row      = (op_reg == OP_RELEASE) ? BUCKET_BITS'(quot) : bucket;
        q_cmd.way      = WAY_W'(rem);
        q_cmd.in_range = (32'(handle_reg) < 32'(N_ENTRIES));
    end

endmodule

// ===== rtl/rblt_queue.sv =====
// Short command queue between the front end and the table engine.
module rblt_queue import rblt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  cmd_t        push_cmd,
    input  logic        pop,
    output cmd_t        pop_cmd,
    output queue_stat_t stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_cmd    = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/rblt_back.sv =====
// Table engine: bucket row memories, search, update and the result register.
module rblt_back import rblt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  queue_stat_t          q_stat,
    input  cmd_t                 q_cmd,
    output logic                 q_pop,
    output logic                 clear_busy,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // result_handle[11:0], ref_count[27:12]
    output logic [STATUS_W-1:0]  m_tuser     // status[2:0]
);

    localparam int KROW_W = WAYS * KEY_W;
    localparam int CROW_W = WAYS * COUNT_BITS;

    logic [KROW_W-1:0] key_mem [ROWS];
    logic [CROW_W-1:0] cnt_mem [ROWS];
    logic [WAYS-1:0]   val_mem [ROWS];

    back_state_t            state_reg, state_next;
    logic [BUCKET_BITS-1:0] clr_row_reg, clr_row_next;
    logic                   out_valid_reg, out_valid_next;

    cmd_t                   cmd_reg;
    logic [KROW_W-1:0]      rd_key_reg;
    logic [CROW_W-1:0]      rd_cnt_reg;
    logic [WAYS-1:0]        rd_val_reg;

    logic [HANDLE_W-1:0]    out_handle_reg;
    logic [OUT_COUNT_W-1:0] out_count_reg;
    logic [STATUS_W-1:0]    out_status_reg;

    logic                   fire;
    logic                   hit, free_ok;
    logic [WAY_W-1:0]       hit_way, free_way, sel_way;
    logic [KEY_W-1:0]       sel_key;
    logic [COUNT_BITS-1:0]  sel_cnt, new_cnt;
    logic                   sel_val;
    logic [ENTRY_W-1:0]     entry;

    logic                   key_we, cnt_we, val_we;
    logic [KROW_W-1:0]      key_wdata;
    logic [CROW_W-1:0]      cnt_wdata;
    logic [WAYS-1:0]        val_wdata;
    logic [BUCKET_BITS-1:0] val_waddr;
    logic                   upd_key, upd_cnt, upd_val, new_val;

    logic [HANDLE_W-1:0]    res_handle;
    logic [OUT_COUNT_W-1:0] res_count;
    logic [STATUS_W-1:0]    res_status;

    assign clear_busy = (state_reg == BK_CLEAR);
    assign q_pop      = (state_reg == BK_WAIT) & ~q_stat.empty;
    assign fire       = (state_reg == BK_EXEC) & (~out_valid_reg | m_tready);

    always_comb begin
        state_next   = state_reg;
        clr_row_next = clr_row_reg;
        case (state_reg)
            BK_CLEAR: begin
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == BUCKET_BITS'(ROWS - 1)) begin
                    state_next = BK_WAIT;
                end
            end
            BK_WAIT: begin
                if (!q_stat.empty) begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (fire) begin
                    state_next = BK_WAIT;
                end
            end
            default: begin
                state_next = BK_WAIT;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_CLEAR;
            clr_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Lowest matching way and lowest free way of the bucket row.
    always_comb begin
        hit      = 1'b0;
        free_ok  = 1'b0;
        hit_way  = '0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (rd_val_reg[w] && (rd_key_reg[w*KEY_W +: KEY_W] == cmd_reg.key)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!rd_val_reg[w]) begin
                free_ok  = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    always_comb begin
        if (cmd_reg.op == OP_RELEASE) begin
            sel_way = cmd_reg.way;
        end else if (hit) begin
            sel_way = hit_way;
        end else begin
            sel_way = free_way;
        end
    end

    assign sel_key = rd_key_reg[sel_way*KEY_W +: KEY_W];
    assign sel_cnt = rd_cnt_reg[sel_way*COUNT_BITS +: COUNT_BITS];
    assign sel_val = rd_val_reg[sel_way];
    assign entry   = ENTRY_W'(cmd_reg.row) * ENTRY_W'(WAYS) + ENTRY_W'(sel_way);

    always_comb begin
        upd_key    = 1'b0;
        upd_cnt    = 1'b0;
        upd_val    = 1'b0;
        new_val    = 1'b0;
        new_cnt    = sel_cnt;
        res_handle = HANDLE_W'(entry);
        res_count  = '0;
        res_status = ST_BAD;
        if (cmd_reg.op == OP_ACQUIRE) begin
            if (hit) begin
                if (sel_cnt == COUNT_MAX) begin
                    res_count  = OUT_COUNT_W'(sel_cnt);
                    res_status = ST_SAT;
                end else begin
                    upd_cnt    = 1'b1;
                    new_cnt    = sel_cnt + 1'b1;
                    res_count  = OUT_COUNT_W'(new_cnt);
                    res_status = ST_FOUND;
                end
            end else if (free_ok) begin
                upd_key    = 1'b1;
                upd_cnt    = 1'b1;
                upd_val    = 1'b1;
                new_val    = 1'b1;
                new_cnt    = COUNT_BITS'(1);
                res_count  = OUT_COUNT_W'(1);
                res_status = ST_INSERTED;
            end else begin
                res_handle = '0;
                res_status = ST_FULL;
            end
        end else begin
            res_handle = cmd_reg.handle;
            if (!cmd_reg.in_range || !sel_val || (sel_key != cmd_reg.key)) begin
                res_status = ST_BAD;
            end else if (sel_cnt <= COUNT_BITS'(1)) begin
                // Last reference gone: only the valid mark needs clearing.
                upd_val    = 1'b1;
                new_val    = 1'b0;
                res_status = ST_FREED;
            end else begin
                upd_cnt    = 1'b1;
                new_cnt    = sel_cnt - 1'b1;
                res_count  = OUT_COUNT_W'(new_cnt);
                res_status = ST_HELD;
            end
        end
    end

    always_comb begin
        key_wdata = rd_key_reg;
        key_wdata[sel_way*KEY_W +: KEY_W] = cmd_reg.key;
        cnt_wdata = rd_cnt_reg;
        cnt_wdata[sel_way*COUNT_BITS +: COUNT_BITS] = new_cnt;
        if (clear_busy) begin
            val_wdata = '0;
            val_waddr = clr_row_reg;
        end else begin
            val_wdata = rd_val_reg;
            val_wdata[sel_way] = new_val;
            val_waddr = cmd_reg.row;
        end
    end

    assign key_we = fire & upd_key;
    assign cnt_we = fire & upd_cnt;
    assign val_we = clear_busy | (fire & upd_val);

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg    <= q_cmd;
            rd_key_reg <= key_mem[q_cmd.row];
            rd_cnt_reg <= cnt_mem[q_cmd.row];
            rd_val_reg <= val_mem[q_cmd.row];
        end
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[cmd_reg.row] <= key_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cmd_reg.row] <= cnt_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[val_waddr] <= val_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_handle_reg <= res_handle;
            out_count_reg  <= res_count;
            out_status_reg <= res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_count_reg, out_handle_reg});
    assign m_tuser  = out_status_reg;

endmodule

// ===== rtl/refcounted_block_lock_table.sv =====
// Top level of the reference-counted block lock table.
//
// Requests enter on the s_ stream: s_tuser is the op (0 acquire, 1 release),
// s_tdata carries the 64-bit block number and the 12-bit entry handle.
// Each request gives exactly one result on the m_ stream: m_tdata carries
// the entry handle and the reference count, m_tuser the status code.
// The table has 2^BUCKET_BITS buckets of WAYS entries, held as one row per
// bucket in key, count and valid memories.
// On its way to m_tvalid when the output is free, a request has its hash
// partial products registered at acceptance, then its bucket formed and its
// command queued, then its bucket row read, and then the compare and write
// back, overlapped with the next request's front work.
// Sustained throughput is set by the row read followed by the write back in
// the table engine: it reads no new row until the last request is written back.
// After reset a clearing pass writes the valid row of every bucket, one row
// a cycle, for all 2^BUCKET_BITS (1024) rows; s_tready stays low until done.
// When the receiver stalls, the result register holds, the engine waits,
// the two-entry command queue fills and then s_tready drops.
module refcounted_block_lock_table import rblt_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // block_number[63:0], entry_handle[75:64]
    input  logic                 s_tuser,    // op[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // result_handle[11:0], ref_count[27:12]
    output logic [STATUS_W-1:0]  m_tuser     // status[2:0]
);

    queue_stat_t q_stat;
    cmd_t        push_cmd;
    cmd_t        pop_cmd;
    logic        q_push;
    logic        q_pop;
    logic        clear_busy;

    rblt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .clear_busy (clear_busy),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    rblt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .stat     (q_stat)
    );

    rblt_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .q_cmd      (pop_cmd),
        .q_pop      (q_pop),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== rtl/rblt_checker.sv =====
// Port-level checks of the lock table results, bound to the top level.
`include "refcounted_block_lock_table_macros.svh"

module rblt_checker import rblt_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    `RBLT_ASSERT_NXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    `RBLT_ASSERT_IMP(a_full_is_zero, aclk, aresetn, m_tvalid && (m_tuser == ST_FULL), m_tdata == '0, "bucket full result must carry handle 0 and count 0")

    `RBLT_ASSERT_IMP(a_no_count, aclk, aresetn, m_tvalid && ((m_tuser == ST_FREED) || (m_tuser == ST_BAD)), m_tdata[27:12] == '0, "freed or bad handle result must carry count 0")

    `RBLT_ASSERT_IMP(a_insert_one, aclk, aresetn, m_tvalid && (m_tuser == ST_INSERTED), m_tdata[27:12] == 16'd1, "inserted entry must have count 1")

    `RBLT_ASSERT_IMP(a_status_code, aclk, aresetn, m_tvalid, (m_tuser != 3'd7) && (m_tdata[31:28] == '0), "unknown status or nonzero padding")

endmodule

bind refcounted_block_lock_table rblt_checker u_rblt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
